@@ hw/rtl/tgc_pkg.sv @@
package tgc_pkg;

	localparam int COORD_BITS = 12;
	localparam int POS_BITS   = COORD_BITS + 1;
	localparam int TIME_BITS  = 32;
	localparam int THR_BITS   = 8;
	localparam int CLICK_BITS = 16;

	localparam int S_TDATA_W = ((2 * COORD_BITS + TIME_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 * POS_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MS      = 3'd4;

	localparam logic [COORD_BITS-1:0] WIDTH_RST  = COORD_BITS'(320);
	localparam logic [COORD_BITS-1:0] HEIGHT_RST = COORD_BITS'(240);
	localparam logic [THR_BITS-1:0]   THRESH_RST = THR_BITS'(10);
	localparam logic [CLICK_BITS-1:0] CLICK_RST  = CLICK_BITS'(500);

	typedef enum logic [2:0] {
		EV_PRESSED  = 3'd0,
		EV_MOTION   = 3'd1,
		EV_CLICKED  = 3'd2,
		EV_LONG     = 3'd3,
		EV_RELEASED = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rotation_t;

	typedef struct packed {
		event_kind_t                kind;
		logic signed [POS_BITS-1:0] x;
		logic signed [POS_BITS-1:0] y;
		logic                       last;
	} event_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] screen_width;
		logic [COORD_BITS-1:0] screen_height;
		rotation_t             rotation;
		logic [THR_BITS-1:0]   move_threshold;
		logic [CLICK_BITS-1:0] click_interval_ms;
	} cfg_t;

endpackage

@@ hw/rtl/tgc_rotate.sv @@
module tgc_rotate (
	input  logic [tgc_pkg::COORD_BITS-1:0]      raw_x,
	input  logic [tgc_pkg::COORD_BITS-1:0]      raw_y,
	input  logic [tgc_pkg::COORD_BITS-1:0]      screen_width,
	input  logic [tgc_pkg::COORD_BITS-1:0]      screen_height,
	input  tgc_pkg::rotation_t                  rotation,
	output logic signed [tgc_pkg::POS_BITS-1:0] pos_x,
	output logic signed [tgc_pkg::POS_BITS-1:0] pos_y
);

	localparam int RW = tgc_pkg::POS_BITS + 1;

	logic signed [RW-1:0] w, h, rx, ry;
	logic signed [RW-1:0] w_m1, h_m1, w_ry, h_rx;
	logic signed [RW-1:0] px, py;

	assign w    = signed'({2'b00, screen_width});
	assign h    = signed'({2'b00, screen_height});
	assign rx   = signed'({2'b00, raw_x});
	assign ry   = signed'({2'b00, raw_y});
	assign w_m1 = w - RW'(1);
	assign h_m1 = h - RW'(1);
	assign w_ry = w - ry;
	assign h_rx = h - rx;

	always_comb begin
		case (rotation)
			tgc_pkg::ROT_90: begin
				px = (w_ry < w_m1) ? w_ry : w_m1;
				py = (rx < h_m1) ? rx : h_m1;
			end
			tgc_pkg::ROT_180: begin
				px = w_m1 - rx;
				py = h_m1 - ry;
			end
			tgc_pkg::ROT_270: begin
				px = (ry < w_m1) ? ry : w_m1;
				py = (h_rx < h_m1) ? h_rx : h_m1;
			end
			default: begin
				px = rx;
				py = ry;
			end
		endcase
	end

	assign pos_x = px[tgc_pkg::POS_BITS-1:0];
	assign pos_y = py[tgc_pkg::POS_BITS-1:0];

endmodule

@@ hw/rtl/tgc_core.sv @@
module tgc_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic signed [tgc_pkg::POS_BITS-1:0] pos_x,
	input  logic signed [tgc_pkg::POS_BITS-1:0] pos_y,
	input  logic                                touch_down,
	input  logic [tgc_pkg::TIME_BITS-1:0]       now_ms,
	input  logic [tgc_pkg::THR_BITS-1:0]        move_threshold,
	input  logic [tgc_pkg::CLICK_BITS-1:0]      click_interval_ms,
	output tgc_pkg::event_t                     ev0,
	output tgc_pkg::event_t                     ev1,
	output logic [1:0]                          n_events
);

	localparam int PB = tgc_pkg::POS_BITS;
	localparam int DW = PB + 1;
	localparam int SW = 2 * PB + 1;

	logic                          touching_q;
	logic signed [PB-1:0]          first_x_q, first_y_q, cur_x_q, cur_y_q;
	logic [tgc_pkg::TIME_BITS-1:0] start_q;

	logic signed [PB-1:0]          ax, ay;
	logic signed [DW-1:0]          dx, dy, ndx, ndy;
	logic [PB-1:0]                 mag_x, mag_y;
	logic [2*PB-1:0]               sq_x, sq_y;
	logic [SW-1:0]                 dist_sq, thr_sq;
	logic                          far;
	logic [tgc_pkg::TIME_BITS-1:0] held;

	// one distance unit: new point vs last on hold, first vs last on release
	assign ax    = touch_down ? pos_x : first_x_q;
	assign ay    = touch_down ? pos_y : first_y_q;
	assign dx    = DW'(ax) - DW'(cur_x_q);
	assign dy    = DW'(ay) - DW'(cur_y_q);
	assign ndx   = -dx;
	assign ndy   = -dy;
	assign mag_x = dx[DW-1] ? ndx[PB-1:0] : dx[PB-1:0];
	assign mag_y = dy[DW-1] ? ndy[PB-1:0] : dy[PB-1:0];
	assign sq_x  = mag_x * mag_x;
	assign sq_y  = mag_y * mag_y;
	assign dist_sq = SW'(sq_x) + SW'(sq_y);
	assign thr_sq = SW'(move_threshold) * SW'(move_threshold);
	assign far   = dist_sq > thr_sq;
	assign held  = now_ms - start_q;

	always_comb begin
		ev0      = '{kind: tgc_pkg::EV_RELEASED, x: cur_x_q, y: cur_y_q, last: 1'b1};
		ev1      = '{kind: tgc_pkg::EV_RELEASED, x: cur_x_q, y: cur_y_q, last: 1'b1};
		n_events = 2'd0;
		if (touch_down) begin
			if (!touching_q) begin
				ev0      = '{kind: tgc_pkg::EV_PRESSED, x: pos_x, y: pos_y, last: 1'b1};
				n_events = 2'd1;
			end else if (far) begin
				ev0      = '{kind: tgc_pkg::EV_MOTION, x: pos_x, y: pos_y, last: 1'b1};
				n_events = 2'd1;
			end
		end else if (touching_q) begin
			if (!far) begin
				ev0.kind = (held < tgc_pkg::TIME_BITS'(click_interval_ms)) ?
					tgc_pkg::EV_CLICKED : tgc_pkg::EV_LONG;
				ev0.x    = first_x_q;
				ev0.y    = first_y_q;
				ev0.last = 1'b0;
				n_events = 2'd2;
			end else begin
				n_events = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touching_q <= 1'b0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			start_q    <= '0;
		end else if (fire) begin
			if (touch_down) begin
				touching_q <= 1'b1;
				if (!touching_q) begin
					first_x_q <= pos_x;
					first_y_q <= pos_y;
					cur_x_q   <= pos_x;
					cur_y_q   <= pos_y;
					start_q   <= now_ms;
				end else if (far) begin
					cur_x_q <= pos_x;
					cur_y_q <= pos_y;
				end
			end else begin
				touching_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/tgc_event_fifo.sv @@
module tgc_event_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      n_push,
	input  tgc_pkg::event_t ev0,
	input  tgc_pkg::event_t ev1,
	output logic            room2,
	output logic            m_tvalid,
	input  logic            m_tready,
	output tgc_pkg::event_t head
);

	tgc_pkg::event_t mem_q [4];
	logic [1:0]      wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [2:0]      count_q;
	logic            pop;

	assign m_tvalid  = count_q != 3'd0;
	assign pop       = m_tvalid && m_tready;
	assign room2     = count_q <= 3'd2;
	assign head      = mem_q[rd_ptr_q];
	assign wr_ptr_p1 = wr_ptr_q + 2'd1;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= ev0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_p1] <= ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + 3'(n_push) - 3'(pop);
		end
	end

endmodule

@@ hw/rtl/touch_gesture_classifier_top.sv @@
// channel  dir  tdata (low bit up)                tuser         tlast
// s_*      in   raw_x, raw_y, now_ms              touch_down    -
// m_*      out  event_x, event_y                  event_kind    last_of_run
// cfg_*    in   write enable, register index, write data (no read-back)
//
// one sample per cycle while two queue slots are free: input register, then
// classify and distance square as combinational logic, results go into a four-entry event queue
// a sample is taken from the input register only when two queue slots are free
// a sample that gives two events writes both into the queue together
// arst_n clears touch state, queue and registers to their defaults
module touch_gesture_classifier_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tgc_pkg::S_TDATA_W-1:0]       s_tdata,  // raw_x, raw_y, now_ms
	input  logic [0:0]                          s_tuser,  // touch_down
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tgc_pkg::M_TDATA_W-1:0]       m_tdata,  // event_x, event_y
	output logic [2:0]                          m_tuser,  // event_kind
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic [tgc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tgc_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

	localparam int CB = tgc_pkg::COORD_BITS;
	localparam int PB = tgc_pkg::POS_BITS;
	localparam int TB = tgc_pkg::TIME_BITS;

	tgc_pkg::cfg_t           cfg_q;
	logic                    v_s1;
	logic [CB-1:0]           raw_x_s1, raw_y_s1;
	logic                    down_s1;
	logic [TB-1:0]           now_s1;
	logic                    room2, fire;
	logic signed [PB-1:0]    pos_x, pos_y;
	tgc_pkg::event_t         ev0, ev1, head;
	logic [1:0]              n_events, n_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width      <= tgc_pkg::WIDTH_RST;
			cfg_q.screen_height     <= tgc_pkg::HEIGHT_RST;
			cfg_q.rotation          <= tgc_pkg::ROT_0;
			cfg_q.move_threshold    <= tgc_pkg::THRESH_RST;
			cfg_q.click_interval_ms <= tgc_pkg::CLICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgc_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata[CB-1:0];
				tgc_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata[CB-1:0];
				tgc_pkg::CFG_ROTATION:
					cfg_q.rotation <= tgc_pkg::rotation_t'(cfg_wdata[1:0]);
				tgc_pkg::CFG_MOVE_THRESH:
					cfg_q.move_threshold <= cfg_wdata[tgc_pkg::THR_BITS-1:0];
				tgc_pkg::CFG_CLICK_MS:
					cfg_q.click_interval_ms <= cfg_wdata[tgc_pkg::CLICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign fire     = v_s1 && room2;
	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_x_s1 <= s_tdata[CB-1:0];
			raw_y_s1 <= s_tdata[2*CB-1:CB];
			now_s1   <= s_tdata[2*CB+TB-1:2*CB];
			down_s1  <= s_tuser[0];
		end
	end

	tgc_rotate u_rotate (
		.raw_x         (raw_x_s1),
		.raw_y         (raw_y_s1),
		.screen_width  (cfg_q.screen_width),
		.screen_height (cfg_q.screen_height),
		.rotation      (cfg_q.rotation),
		.pos_x         (pos_x),
		.pos_y         (pos_y)
	);

	tgc_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (fire),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.touch_down        (down_s1),
		.now_ms            (now_s1),
		.move_threshold    (cfg_q.move_threshold),
		.click_interval_ms (cfg_q.click_interval_ms),
		.ev0               (ev0),
		.ev1               (ev1),
		.n_events          (n_events)
	);

	assign n_push = fire ? n_events : 2'd0;

	tgc_event_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_push   (n_push),
		.ev0      (ev0),
		.ev1      (ev1),
		.room2    (room2),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {{(tgc_pkg::M_TDATA_W - 2 * PB){1'b0}}, head.y, head.x};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

@@ tb/touch_gesture_classifier_top_tb.sv @@
`timescale 1ns / 100ps

module touch_gesture_classifier_top_tb;
	import tgc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 125;

	typedef struct {
		logic [COORD_BITS-1:0] rx;
		logic [COORD_BITS-1:0] ry;
		logic                  down;
		logic [TIME_BITS-1:0]  now;
		bit                    drain;
	} touch_sample_t;

	typedef struct {
		event_kind_t                kind;
		logic signed [POS_BITS-1:0] x;
		logic signed [POS_BITS-1:0] y;
		logic                       last;
	} gesture_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	touch_gesture_classifier_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	touch_sample_t  samples_to_send[$];
	gesture_event_t events_due[$];
	touch_sample_t  sample_on_bus;

	cfg_t shadow_cfg;
	logic touching;
	int first_x, first_y, last_x, last_y;
	logic [TIME_BITS-1:0] press_start;

	int samples_queued = 0;
	int samples_sent = 0;
	int events_seen = 0;
	int mismatches = 0;
	int settings_used = 0;
	int kind_seen[8];
	int cycle_count = 0;
	int send_gap = 0;
	int send_calm = 0;
	int recv_stall = 0;
	int recv_calm = 0;
	logic [TIME_BITS-1:0] tick;

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v < 0)
			return 0;
		if (v > 4095)
			return 4095;
		return v;
	endfunction

	function automatic longint dist_sq(input int ax, input int ay, input int bx, input int by);
		longint dx, dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return dx * dx + dy * dy;
	endfunction

	function automatic void note_event(input event_kind_t kind, input int x, input int y,
			input logic last);
		gesture_event_t ev;
		ev.kind = kind;
		ev.x = x[POS_BITS-1:0];
		ev.y = y[POS_BITS-1:0];
		ev.last = last;
		events_due.push_back(ev);
	endfunction

	function automatic void classify_sample(input touch_sample_t s);
		int w, h, rx, ry, px, py;
		longint thr_sq;
		logic [TIME_BITS-1:0] held;
		w = int'(shadow_cfg.screen_width);
		h = int'(shadow_cfg.screen_height);
		rx = int'(s.rx);
		ry = int'(s.ry);
		px = rx;
		py = ry;
		thr_sq = longint'(shadow_cfg.move_threshold) * longint'(shadow_cfg.move_threshold);
		case (shadow_cfg.rotation)
			ROT_90: begin
				px = min_int(w - ry, w - 1);
				py = min_int(rx, h - 1);
			end
			ROT_180: begin
				px = w - rx - 1;
				py = h - ry - 1;
			end
			ROT_270: begin
				px = min_int(ry, w - 1);
				py = min_int(h - rx, h - 1);
			end
			default: ;
		endcase
		if (s.down) begin
			if (!touching) begin
				touching = 1'b1;
				first_x = px;
				first_y = py;
				last_x = px;
				last_y = py;
				press_start = s.now;
				note_event(EV_PRESSED, px, py, 1'b1);
			end else if (dist_sq(px, py, last_x, last_y) > thr_sq) begin
				last_x = px;
				last_y = py;
				note_event(EV_MOTION, px, py, 1'b1);
			end
		end else if (touching) begin
			touching = 1'b0;
			if (dist_sq(first_x, first_y, last_x, last_y) <= thr_sq) begin
				held = s.now - press_start;
				note_event((held < 32'(shadow_cfg.click_interval_ms)) ? EV_CLICKED : EV_LONG,
					first_x, first_y, 1'b0);
			end
			note_event(EV_RELEASED, last_x, last_y, 1'b1);
		end
	endfunction

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				classify_sample(sample_on_bus);
				samples_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (samples_to_send.size() != 0 &&
						!(samples_to_send[0].drain && events_due.size() != 0)) begin
					sample_on_bus = samples_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {sample_on_bus.now, sample_on_bus.ry, sample_on_bus.rx};
					s_tuser <= sample_on_bus.down;
					send_gap = pick_gap(send_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// event monitor
	always @(posedge clk) begin : event_monitor
		gesture_event_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				events_seen++;
				kind_seen[m_tuser]++;
				if (events_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected event: kind %0d x %0d y %0d last %0b",
							m_tuser, $signed(m_tdata[POS_BITS-1:0]),
							$signed(m_tdata[2*POS_BITS-1:POS_BITS]), m_tlast);
				end else begin
					want = events_due.pop_front();
					if (m_tuser !== want.kind || m_tdata[POS_BITS-1:0] !== want.x ||
							m_tdata[2*POS_BITS-1:POS_BITS] !== want.y || m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("event mismatch: want kind %0d x %0d y %0d last %0b, got kind %0d x %0d y %0d last %0b",
								want.kind, want.x, want.y, want.last, m_tuser,
								$signed(m_tdata[POS_BITS-1:0]),
								$signed(m_tdata[2*POS_BITS-1:POS_BITS]), m_tlast);
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_stall = pick_gap(recv_calm);
			end
		end
	end

	function automatic void queue_sample(input int x, input int y, input bit down,
			input logic [TIME_BITS-1:0] now);
		touch_sample_t s;
		s.rx = x[COORD_BITS-1:0];
		s.ry = y[COORD_BITS-1:0];
		s.down = down;
		s.now = now;
		s.drain = 1'b0;
		samples_to_send.push_back(s);
		samples_queued++;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_DAT_W-1:0];
		case (idx)
			CFG_SCREEN_WIDTH:  shadow_cfg.screen_width = val[COORD_BITS-1:0];
			CFG_SCREEN_HEIGHT: shadow_cfg.screen_height = val[COORD_BITS-1:0];
			CFG_ROTATION:      shadow_cfg.rotation = rotation_t'(val[1:0]);
			CFG_MOVE_THRESH:   shadow_cfg.move_threshold = val[THR_BITS-1:0];
			CFG_CLICK_MS:      shadow_cfg.click_interval_ms = val[CLICK_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_config(input int unsigned w, input int unsigned h,
			input int unsigned rot, input int unsigned thr, input int unsigned click);
		write_reg(CFG_SCREEN_WIDTH, w);
		write_reg(CFG_SCREEN_HEIGHT, h);
		write_reg(CFG_ROTATION, rot);
		write_reg(CFG_MOVE_THRESH, thr);
		write_reg(CFG_CLICK_MS, click);
		settings_used++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (samples_to_send.size() != 0 || s_tvalid || events_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 1;
		if (r < 20)
			return 4095;
		if (r < 24)
			return 0;
		return $urandom_range(2, 4094);
	endfunction

	task automatic queue_gesture();
		int x, y, holds, span, r, thr;
		logic [TIME_BITS-1:0] t0, dur, click;
		thr = int'(shadow_cfg.move_threshold);
		click = 32'(shadow_cfg.click_interval_ms);
		r = $urandom_range(0, 99);
		// noise: lone sample of any kind
		if (r < 12) begin
			queue_sample($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 1), $urandom);
			return;
		end
		case ($urandom_range(0, 3))
			0: begin
				x = $urandom_range(0, 4095);
				y = $urandom_range(0, 4095);
			end
			1: begin
				x = ($urandom_range(0, 1) != 0) ? 4095 : 0;
				y = ($urandom_range(0, 1) != 0) ? 4095 : 0;
			end
			default: begin
				x = $urandom_range(0, 400);
				y = $urandom_range(0, 300);
			end
		endcase
		t0 = tick;
		queue_sample(x, y, 1'b1, t0);
		holds = $urandom_range(0, 5);
		for (int i = 0; i < holds; i++) begin
			span = ($urandom_range(0, 1) != 0) ? thr / 2 : thr * 3 + 8;
			x = clamp_coord(x + int'($urandom_range(0, 2 * span)) - span);
			y = clamp_coord(y + int'($urandom_range(0, 2 * span)) - span);
			tick += $urandom_range(1, 50);
			queue_sample(x, y, 1'b1, tick);
		end
		r = $urandom_range(0, 99);
		if (r < 40)
			dur = (click == 0) ? 0 : $urandom_range(0, click - 1);
		else if (r < 50)
			dur = click;
		else if (r < 58)
			dur = (click == 0) ? 0 : click - 1;
		else if (r < 90)
			dur = click + $urandom_range(1, 3000);
		else
			dur = $urandom;
		tick = t0 + dur;
		queue_sample($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, tick);
		tick += $urandom_range(1, 100);
		if ($urandom_range(0, 19) == 0)
			samples_to_send[$].drain = 1'b1;
	endtask

	initial begin : stimulus
		int thr, click, r, start;
		shadow_cfg.screen_width = WIDTH_RST;
		shadow_cfg.screen_height = HEIGHT_RST;
		shadow_cfg.rotation = ROT_0;
		shadow_cfg.move_threshold = THRESH_RST;
		shadow_cfg.click_interval_ms = CLICK_RST;
		touching = 1'b0;
		first_x = 0;
		first_y = 0;
		last_x = 0;
		last_y = 0;
		press_start = '0;
		foreach (kind_seen[i])
			kind_seen[i] = 0;
		tick = 32'hFFFF0000 - $urandom_range(0, 65535);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults after reset
		queue_sample(5, 5, 1'b0, 100);
		queue_sample(0, 0, 1'b1, 0);
		queue_sample(0, 0, 1'b1, 10);
		queue_sample(4095, 4095, 1'b1, 20);
		queue_sample(4095, 4095, 1'b1, 30);
		queue_sample(77, 66, 1'b0, 40);
		queue_sample(100, 100, 1'b1, 1000);
		queue_sample(105, 105, 1'b1, 1100);
		queue_sample(108, 100, 1'b1, 1200);
		queue_sample(12'hABC, 12'h543, 1'b0, 1499);
		queue_sample(200, 50, 1'b1, 2000);
		queue_sample(200, 50, 1'b0, 2500);
		queue_sample(10, 20, 1'b1, 32'hFFFFFF00);
		queue_sample(3000, 4000, 1'b0, 32'h00000010);
		queue_sample(4095, 0, 1'b1, 32'hFFFFFFFF);
		queue_sample(4095, 0, 1'b1, 0);
		queue_sample(0, 4095, 1'b1, 5);
		queue_sample(0, 0, 1'b0, 32'h80000000);
		samples_to_send[$ - 4].drain = 1'b1;
		wait_idle();

		// zero screen size, no threshold, touch left held
		write_config(0, 0, ROT_180, 0, 0);
		queue_sample(4095, 4095, 1'b1, 7);
		queue_sample(4095, 4095, 1'b1, 7);
		queue_sample(0, 0, 1'b1, 8);
		wait_idle();

		// new settings while the touch is still down
		write_config(4095, 4095, ROT_90, 255, 65535);
		queue_sample(4095, 0, 1'b1, 9);
		queue_sample(0, 0, 1'b0, 10);
		wait_idle();

		write_reg(CFG_ROTATION, ROT_270);
		@(negedge clk);
		queue_sample(0, 4095, 1'b1, 100);
		queue_sample(10, 4000, 1'b0, 65634);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			r = $urandom_range(0, 99);
			thr = (r < 15) ? 0 : (r < 30) ? 255 : $urandom_range(1, 40);
			r = $urandom_range(0, 99);
			click = (r < 10) ? 0 : (r < 20) ? 65535 : $urandom_range(1, 3000);
			write_config(pick_size(), pick_size(), p % 4, thr, click);
			start = samples_queued;
			while (samples_queued - start < ITEMS_PER_PHASE) begin
				queue_gesture();
				if (samples_queued - start >= 10 && samples_queued - start < 16)
					samples_to_send[$].drain = 1'b1;
			end
			wait_idle();
		end

		$display("sent %0d touch samples over %0d register settings, checked %0d events",
			samples_sent, settings_used, events_seen);
		$display("pressed %0d motion %0d clicked %0d long %0d released %0d",
			kind_seen[EV_PRESSED], kind_seen[EV_MOTION], kind_seen[EV_CLICKED],
			kind_seen[EV_LONG], kind_seen[EV_RELEASED]);
		if (mismatches == 0 && events_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
